[design/sbd_pkg.sv]
// Package for the steered brief descriptor block.
// Holds sizes, the job struct, the back-end state type and the CORDIC angle table.
// No dependencies.
package sbd_pkg;
    localparam int PATCH_SIDE  = 32;
    localparam int DESC_BITS   = 256;
    localparam int MAX_BUCKETS = 32;
    localparam int PIX_TOTAL   = PATCH_SIDE * PATCH_SIDE;
    localparam int PIX_AW      = $clog2(PIX_TOTAL);
    localparam int PAIR_DEPTH  = MAX_BUCKETS * DESC_BITS;
    localparam int PAIR_AW     = $clog2(PAIR_DEPTH);
    localparam int PAIR_W      = 20;
    localparam int PIX_W       = 16;
    localparam int SUM_W       = 32;
    localparam int CORD_W      = 35;
    localparam int CORD_STEPS  = 16;
    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = DESC_BITS / WORD_W;
    localparam int RADIUS_SQ   = (PATCH_SIDE - 1) * (PATCH_SIDE - 1);
    localparam logic [5:0] NB_RESET = 6'd30;
    localparam logic [5:0] NB_MAX   = 6'd32;

    typedef struct packed {
        logic [SUM_W-1:0] x_sum;
        logic [SUM_W-1:0] y_sum;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_NORM,
        BK_ROT,
        BK_ITER,
        BK_MUL,
        BK_SEL,
        BK_CMP,
        BK_OUT
    } t_back_state;

    function automatic logic [15:0] atan_turn(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd8192;
            4'd1:    v = 16'd4836;
            4'd2:    v = 16'd2555;
            4'd3:    v = 16'd1297;
            4'd4:    v = 16'd651;
            4'd5:    v = 16'd326;
            4'd6:    v = 16'd163;
            4'd7:    v = 16'd81;
            4'd8:    v = 16'd41;
            4'd9:    v = 16'd20;
            4'd10:   v = 16'd10;
            4'd11:   v = 16'd5;
            4'd12:   v = 16'd3;
            4'd13:   v = 16'd1;
            4'd14:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction
endpackage

[design/steered_brief_descriptor.sv]
// Steered brief descriptor engine.
// Input channel: i_in_valid / o_in_stall. A transaction with req_type 0 loads one
// pair entry (bucket_sel, bit_index, two points); req_type 1 delivers the next
// patch pixel in raster order, 32 x 32 pixels per patch.
// Output channel: o_out_valid / i_out_stall. After the last pixel four transactions
// leave, one per 64-bit descriptor word, last_word set on the fourth.
// Loads and pixels are accepted back to back while o_in_stall is low. After the last
// pixel the input stalls while the back end runs: the job queue, normalizing (up to
// 30 shifts and a final check), a rotate, 16 CORDIC steps, the bucket multiply and
// select, then per word a pass through the pair table and patch store read ports
// and the output register. A job with zero sums skips normalizing, rotate and CORDIC.
// A receiver stall holds the current word and freezes the back end.
// Reset (synchronous, active low) clears the pixel counter, sums, queue and back-end
// state and sets num_buckets to 30; pair table and patch store contents are kept and
// undefined until written. i_cfg_we writes num_buckets; the user must assert it only
// while the block is idle, and the block itself does not enforce this.
module steered_brief_descriptor import sbd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [4:0]         i_bucket_sel,
    input  logic [7:0]         i_bit_index,
    input  logic [4:0]         i_first_x,
    input  logic [4:0]         i_first_y,
    input  logic [4:0]         i_second_x,
    input  logic [4:0]         i_second_y,
    input  logic signed [15:0] i_pixel,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_word_index,
    output logic [63:0]        o_descriptor_word,
    output logic [4:0]         o_chosen_bucket,
    output logic               o_last_word
);
    logic [5:0]         r_num_buckets;
    logic               back_busy, job_pop, job_valid;
    t_job               job;
    logic               pair_we, pix_we;
    logic [PAIR_AW-1:0] pair_waddr, pair_raddr;
    logic [PAIR_W-1:0]  pair_wdata, pair_rdata;
    logic [PIX_AW-1:0]  pix_waddr, pix_raddr_a, pix_raddr_b;
    logic [PIX_W-1:0]   pix_wdata, pix_rdata_a, pix_rdata_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_buckets <= NB_RESET;
        end else if (i_cfg_we) begin
            r_num_buckets <= i_cfg_data;
        end
    end

    sbd_front u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_req_type, .i_bucket_sel,
        .i_bit_index, .i_first_x, .i_first_y, .i_second_x, .i_second_y, .i_pixel,
        .i_back_busy(back_busy), .i_job_pop(job_pop), .o_job_valid(job_valid),
        .o_job(job), .o_pair_we(pair_we), .o_pair_waddr(pair_waddr),
        .o_pair_wdata(pair_wdata), .o_pix_we(pix_we), .o_pix_waddr(pix_waddr),
        .o_pix_wdata(pix_wdata)
    );

    sbd_ram #(.WIDTH(PAIR_W), .DEPTH(PAIR_DEPTH)) u_pair_ram (
        .i_clk, .i_we(pair_we), .i_waddr(pair_waddr), .i_wdata(pair_wdata),
        .i_raddr(pair_raddr), .o_rdata(pair_rdata)
    );

    sbd_ram #(.WIDTH(PIX_W), .DEPTH(PIX_TOTAL)) u_pix_ram_a (
        .i_clk, .i_we(pix_we), .i_waddr(pix_waddr), .i_wdata(pix_wdata),
        .i_raddr(pix_raddr_a), .o_rdata(pix_rdata_a)
    );

    sbd_ram #(.WIDTH(PIX_W), .DEPTH(PIX_TOTAL)) u_pix_ram_b (
        .i_clk, .i_we(pix_we), .i_waddr(pix_waddr), .i_wdata(pix_wdata),
        .i_raddr(pix_raddr_b), .o_rdata(pix_rdata_b)
    );

    sbd_back u_back (
        .i_clk, .i_rst_n, .i_num_buckets(r_num_buckets), .i_job_valid(job_valid),
        .i_job(job), .o_job_pop(job_pop), .o_busy(back_busy),
        .o_pair_raddr(pair_raddr), .i_pair_rdata(pair_rdata),
        .o_pix_raddr_a(pix_raddr_a), .o_pix_raddr_b(pix_raddr_b),
        .i_pix_rdata_a(pix_rdata_a), .i_pix_rdata_b(pix_rdata_b),
        .o_out_valid, .i_out_stall, .o_word_index, .o_descriptor_word,
        .o_chosen_bucket, .o_last_word
    );
endmodule

[design/sbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/sbd_front.sv]
// Front end: accepts pair loads and pixels, writes the stores, sums moments.
// Hands a finished patch to the back end through a one-entry job queue. Uses sbd_pkg.
module sbd_front import sbd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [4:0]         i_bucket_sel,
    input  logic [7:0]         i_bit_index,
    input  logic [4:0]         i_first_x,
    input  logic [4:0]         i_first_y,
    input  logic [4:0]         i_second_x,
    input  logic [4:0]         i_second_y,
    input  logic signed [15:0] i_pixel,
    input  logic               i_back_busy,
    input  logic               i_job_pop,
    output logic               o_job_valid,
    output t_job               o_job,
    output logic               o_pair_we,
    output logic [PAIR_AW-1:0] o_pair_waddr,
    output logic [PAIR_W-1:0]  o_pair_wdata,
    output logic               o_pix_we,
    output logic [PIX_AW-1:0]  o_pix_waddr,
    output logic [PIX_W-1:0]   o_pix_wdata
);
    logic [PIX_AW-1:0] r_count, n_count;
    logic [SUM_W-1:0]  r_xs, n_xs, r_ys, n_ys;
    logic              r_job_valid, n_job_valid;
    t_job              r_job, n_job;
    logic              acc, pix_acc, last_pix, in_circle;
    logic signed [6:0]  dx2, dy2;
    logic [11:0]        rsq;
    logic signed [22:0] px, py;
    logic [SUM_W-1:0]   sx, sy;

    assign o_in_stall = r_job_valid | i_back_busy;
    assign acc        = i_in_valid & ~o_in_stall;
    assign pix_acc    = acc & i_req_type;
    assign last_pix   = pix_acc & (r_count == PIX_AW'(PIX_TOTAL - 1));

    always_comb begin
        dx2       = $signed({1'b0, r_count[4:0], 1'b0}) - 7'sd31;
        dy2       = 7'sd31 - $signed({1'b0, r_count[9:5], 1'b0});
        rsq       = 12'(dx2) * 12'(dx2) + 12'(dy2) * 12'(dy2);
        in_circle = rsq <= 12'(RADIUS_SQ);
        px        = dx2 * i_pixel;
        py        = dy2 * i_pixel;
        sx        = in_circle ? r_xs + SUM_W'(px) : r_xs;
        sy        = in_circle ? r_ys + SUM_W'(py) : r_ys;
    end

    always_comb begin
        n_count     = r_count;
        n_xs        = r_xs;
        n_ys        = r_ys;
        n_job_valid = r_job_valid & ~i_job_pop;
        n_job       = r_job;
        if (pix_acc) begin
            n_count = r_count + 1'b1;
            n_xs    = sx;
            n_ys    = sy;
        end
        if (last_pix) begin
            n_xs        = '0;
            n_ys        = '0;
            n_job_valid = 1'b1;
            n_job.x_sum = sx;
            n_job.y_sum = sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_xs        <= '0;
            r_ys        <= '0;
            r_job_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_xs        <= n_xs;
            r_ys        <= n_ys;
            r_job_valid <= n_job_valid;
        end
        r_job <= n_job;
    end

    assign o_job_valid  = r_job_valid;
    assign o_job        = r_job;
    assign o_pair_we    = acc & ~i_req_type;
    assign o_pair_waddr = {i_bucket_sel, i_bit_index};
    assign o_pair_wdata = {i_second_y, i_second_x, i_first_y, i_first_x};
    assign o_pix_we     = pix_acc;
    assign o_pix_waddr  = r_count;
    assign o_pix_wdata  = i_pixel;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_pix |=> r_job_valid && r_count == '0)
        else $error("last pixel did not queue a job");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> o_in_stall)
        else $error("input taken with a job pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_valid && !i_job_pop) |=> r_job_valid && $stable(r_job))
        else $error("queued job lost or changed");
endmodule

[design/sbd_back.sv]
// Back end: CORDIC orientation, bucket selection, pair comparison, word output.
// Reads the pair table and two copies of the patch store. Uses sbd_pkg.
module sbd_back import sbd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [5:0]         i_num_buckets,
    input  logic               i_job_valid,
    input  t_job               i_job,
    output logic               o_job_pop,
    output logic               o_busy,
    output logic [PAIR_AW-1:0] o_pair_raddr,
    input  logic [PAIR_W-1:0]  i_pair_rdata,
    output logic [PIX_AW-1:0]  o_pix_raddr_a,
    output logic [PIX_AW-1:0]  o_pix_raddr_b,
    input  logic [PIX_W-1:0]   i_pix_rdata_a,
    input  logic [PIX_W-1:0]   i_pix_rdata_b,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_word_index,
    output logic [63:0]        o_descriptor_word,
    output logic [4:0]         o_chosen_bucket,
    output logic               o_last_word
);
    t_back_state r_state, n_state;
    logic signed [CORD_W-1:0] r_x, r_y, xs, ys, ax, ay;
    logic [15:0]  r_z;
    logic [3:0]   r_i;
    logic [21:0]  r_prod;
    logic [5:0]   nb, q;
    logic [4:0]   r_bucket;
    logic [1:0]   r_word;
    logic [6:0]   r_cnt;
    logic         r_v1, r_v2;
    logic [63:0]  r_bits;
    logic         needs_shift, zero_in, out_done;

    always_comb begin
        nb = i_num_buckets;
        if (nb == 6'd0) nb = 6'd1;
        if (nb > NB_MAX) nb = NB_MAX;
        ax          = r_x[CORD_W-1] ? -r_x : r_x;
        ay          = r_y[CORD_W-1] ? -r_y : r_y;
        needs_shift = (ax < CORD_W'(1 << 30)) && (ay < CORD_W'(1 << 30));
        xs          = r_x >>> r_i;
        ys          = r_y >>> r_i;
        zero_in     = (i_job.x_sum == '0) && (i_job.y_sum == '0);
        q           = 6'((23'(r_prod) + 23'd32768) >> 16);
        out_done    = ~i_out_stall & (r_word == 2'(NUM_WORDS - 1));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (i_job_valid) n_state = zero_in ? BK_MUL : BK_NORM;
            BK_NORM: if (!needs_shift) n_state = BK_ROT;
            BK_ROT:  n_state = BK_ITER;
            BK_ITER: if (r_i == 4'(CORD_STEPS - 1)) n_state = BK_MUL;
            BK_MUL:  n_state = BK_SEL;
            BK_SEL:  n_state = BK_CMP;
            BK_CMP:  if (r_cnt == 7'd65) n_state = BK_OUT;
            BK_OUT: begin
                if (!i_out_stall) n_state = out_done ? BK_IDLE : BK_CMP;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop   = (r_state == BK_IDLE) & i_job_valid;
        o_busy      = r_state != BK_IDLE;
        o_out_valid = r_state == BK_OUT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == BK_CMP) && (r_cnt < 7'd64);
            r_v2    <= r_v1;
        end
        case (r_state)
            BK_IDLE: begin
                r_x <= CORD_W'($signed(i_job.x_sum));
                r_y <= CORD_W'($signed(i_job.y_sum));
                r_z <= '0;
                r_i <= '0;
            end
            BK_NORM: begin
                if (needs_shift) begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                end
            end
            BK_ROT: begin
                if (r_x[CORD_W-1]) begin
                    r_x <= -r_x;
                    r_y <= -r_y;
                    r_z <= 16'h8000;
                end
            end
            BK_ITER: begin
                r_i <= r_i + 1'b1;
                if (!r_y[CORD_W-1]) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_turn(r_i);
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_turn(r_i);
                end
            end
            BK_MUL: r_prod <= 22'(r_z) * 22'(nb);
            BK_SEL: begin
                r_bucket <= (q == nb) ? 5'd0 : q[4:0];
                r_word   <= '0;
                r_cnt    <= '0;
            end
            BK_CMP: r_cnt <= r_cnt + 1'b1;
            BK_OUT: begin
                if (!i_out_stall) begin
                    r_word <= r_word + 1'b1;
                    r_cnt  <= '0;
                end
            end
            default: ;
        endcase
        if (r_v2) begin
            r_bits <= {$signed(i_pix_rdata_a) > $signed(i_pix_rdata_b), r_bits[63:1]};
        end
    end

    assign o_pair_raddr      = {r_bucket, r_word, r_cnt[5:0]};
    assign o_pix_raddr_a     = {i_pair_rdata[9:5], i_pair_rdata[4:0]};
    assign o_pix_raddr_b     = {i_pair_rdata[19:15], i_pair_rdata[14:10]};
    assign o_word_index      = r_word;
    assign o_descriptor_word = r_bits;
    assign o_chosen_bucket   = r_bucket;
    assign o_last_word       = r_word == 2'(NUM_WORDS - 1);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_CMP |-> r_cnt <= 7'd65)
        else $error("compare counter overran");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(r_bits))
        else $error("stalled word changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> r_state != BK_IDLE)
        else $error("job popped without starting");
endmodule

[bench/tb.sv]
// Testbench for steered_brief_descriptor: fills the pair table, streams patches and
// checks every descriptor word against an in-bench orientation and comparison predictor.
// Depends on design/sbd_pkg.sv and design/steered_brief_descriptor.sv.
`timescale 1ns / 1ps
module tb import sbd_pkg::*; ();

    typedef enum int { PK_ZERO, PK_CONST, PK_RAMP_X, PK_RAMP_NX, PK_RAMP_Y, PK_CHECKER,
                       PK_NOISE } t_patch_kind;

    typedef struct {
        logic [1:0]  widx;
        logic [63:0] bits;
        logic [4:0]  bucket;
        logic        last;
    } t_desc_word;

    typedef struct {
        t_patch_kind kind;
        int          level;
        logic [5:0]  nb;
        int          typed_bucket;
    } t_patch_row;

    localparam int ANGLE_STEP [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                      41, 20, 10, 5, 3, 1, 1, 0};
    localparam int CYCLE_LIMIT = 600000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [5:0]         i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_req_type = 1'b0;
    logic [4:0]         i_bucket_sel = '0;
    logic [7:0]         i_bit_index = '0;
    logic [4:0]         i_first_x = '0;
    logic [4:0]         i_first_y = '0;
    logic [4:0]         i_second_x = '0;
    logic [4:0]         i_second_y = '0;
    logic signed [15:0] i_pixel = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_word_index;
    logic [63:0]        o_descriptor_word;
    logic [4:0]         o_chosen_bucket;
    logic               o_last_word;

    steered_brief_descriptor dut (.*);

    always #2 i_clk = ~i_clk;

    logic [19:0]        pair_tab [PAIR_DEPTH];
    logic signed [15:0] patch_px [PIX_TOTAL];
    int                 x_sum, y_sum, px_count;
    logic [5:0]         bucket_cfg = NB_RESET;
    int                 typed_bucket = -1;
    t_desc_word         desc_q [$];
    bit                 failed = 1'b0;
    bit                 quiet = 1'b0;
    int                 cycles = 0;

    function automatic int turn_of(longint x, longint y);
        longint ax, ay, xs, ys;
        int     z;
        z = 0;
        if (x == 0 && y == 0) return 0;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        while (ax < (64'sd1 << 30) && ay < (64'sd1 << 30)) begin
            x = x * 2; y = y * 2; ax = ax * 2; ay = ay * 2;
        end
        if (x < 0) begin
            x = -x; y = -y; z = 32'h8000;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + ANGLE_STEP[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ANGLE_STEP[i];
            end
        end
        return z & 16'hFFFF;
    endfunction

    task automatic predict_descriptor();
        int         n, turn, bucket;
        logic [19:0] e;
        t_desc_word w;
        n = bucket_cfg == 0 ? 1 : (bucket_cfg > MAX_BUCKETS ? MAX_BUCKETS : bucket_cfg);
        turn = turn_of(longint'(x_sum), longint'(y_sum));
        bucket = ((turn * n + 32768) >> 16) % n;
        for (int k = 0; k < NUM_WORDS; k++) begin
            w.bits = '0;
            for (int b = 0; b < 64; b++) begin
                e = pair_tab[bucket * DESC_BITS + k * 64 + b];
                if (patch_px[e[9:5] * PATCH_SIDE + e[4:0]] >
                    patch_px[e[19:15] * PATCH_SIDE + e[14:10]])
                    w.bits[b] = 1'b1;
            end
            w.widx = k[1:0];
            w.bucket = bucket[4:0];
            w.last = (k == NUM_WORDS - 1);
            if (typed_bucket >= 0) begin
                w.bucket = typed_bucket[4:0];
                w.bits = '0;
            end
            desc_q.push_back(w);
        end
        x_sum = 0;
        y_sum = 0;
        px_count = 0;
    endtask

    task automatic absorb_transaction(logic req, logic [4:0] bsel, logic [7:0] bidx,
                                      logic [19:0] pair, logic signed [15:0] pix);
        int col, row, dx2, dy2;
        if (!req) begin
            pair_tab[bsel * DESC_BITS + bidx] = pair;
            return;
        end
        patch_px[px_count] = pix;
        col = px_count % PATCH_SIDE;
        row = px_count / PATCH_SIDE;
        dx2 = 2 * col - (PATCH_SIDE - 1);
        dy2 = (PATCH_SIDE - 1) - 2 * row;
        if (dx2 * dx2 + dy2 * dy2 <= RADIUS_SQ) begin
            x_sum = x_sum + dx2 * int'(pix);
            y_sum = y_sum + dy2 * int'(pix);
        end
        px_count++;
        if (px_count == PIX_TOTAL) predict_descriptor();
    endtask

    task automatic send(logic req, logic [4:0] bsel, logic [7:0] bidx, logic [19:0] pair,
                        logic signed [15:0] pix);
        if (!quiet && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_bucket_sel <= bsel;
        i_bit_index  <= bidx;
        i_first_x    <= pair[4:0];
        i_first_y    <= pair[9:5];
        i_second_x   <= pair[14:10];
        i_second_y   <= pair[19:15];
        i_pixel      <= pix;
        do @(posedge i_clk); while (o_in_stall);
        absorb_transaction(req, bsel, bidx, pair, pix);
    endtask

    task automatic send_load(logic [4:0] bsel, logic [7:0] bidx, logic [19:0] pair);
        send(1'b0, bsel, bidx, pair, 16'($urandom));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (desc_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [5:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        bucket_cfg = v;
    endtask

    task automatic send_patch(t_patch_kind kind, int level, bit mix_loads);
        int v, col, row;
        for (int p = 0; p < PIX_TOTAL; p++) begin
            col = p % PATCH_SIDE;
            row = p / PATCH_SIDE;
            case (kind)
                PK_ZERO:    v = 0;
                PK_CONST:   v = level;
                PK_RAMP_X:  v = (col - 16) * level;
                PK_RAMP_NX: v = (16 - col) * level;
                PK_RAMP_Y:  v = (16 - row) * level;
                PK_CHECKER: v = ((col ^ row) & 1) ? 32767 : -32768;
                default:    v = $urandom;
            endcase
            if (kind == PK_NOISE && level > 0)
                v = (col - 16) * $urandom_range(level) + (16 - row) * $urandom_range(level)
                    - $urandom_range(2000);
            send(1'b1, 5'($urandom), 8'($urandom), 20'($urandom), 16'(v));
            if (mix_loads && $urandom_range(99) < 4)
                send_load(5'($urandom), 8'($urandom), 20'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_desc_word w;
        if (o_out_valid && !i_out_stall) begin
            if (desc_q.size() == 0) begin
                $display("%0t: unexpected word idx %0d data %h", $time, o_word_index,
                         o_descriptor_word);
                failed = 1'b1;
            end else begin
                w = desc_q.pop_front();
                if (o_word_index !== w.widx || o_descriptor_word !== w.bits ||
                    o_chosen_bucket !== w.bucket || o_last_word !== w.last) begin
                    $display("%0t: expected idx %0d word %h bucket %0d last %0d", $time,
                             w.widx, w.bits, w.bucket, w.last);
                    $display("%0t: actual   idx %0d word %h bucket %0d last %0d", $time,
                             o_word_index, o_descriptor_word, o_chosen_bucket, o_last_word);
                    failed = 1'b1;
                end
            end
        end
        i_out_stall <= !quiet && ($urandom_range(99) < 8);
    end

    t_patch_row directed [8] = '{
        '{PK_ZERO,    0,      6'd1,  0},
        '{PK_CONST,   32767,  6'd32, 0},
        '{PK_CONST,   -32768, 6'd0,  0},
        '{PK_RAMP_X,  1000,   6'd63, -1},
        '{PK_RAMP_NX, 1000,   6'd30, -1},
        '{PK_RAMP_Y,  2000,   6'd4,  -1},
        '{PK_CHECKER, 0,      6'd7,  -1},
        '{PK_NOISE,   0,      6'd32, -1}
    };

    initial begin
        t_patch_kind k;
        x_sum = 0;
        y_sum = 0;
        px_count = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // fill every entry so no bucket can read an unwritten pair
        for (int b = 0; b < MAX_BUCKETS; b++)
            for (int i = 0; i < DESC_BITS; i++)
                send_load(b[4:0], i[7:0], (b == 0 && i < 2) ? {20{i[0]}} : 20'($urandom));
        for (int r = 0; r < 8; r++) begin
            write_buckets(directed[r].nb);
            typed_bucket = directed[r].typed_bucket;
            send_patch(directed[r].kind, directed[r].level, 1'b0);
            drain();
        end
        typed_bucket = -1;
        for (int r = 0; r < 14; r++) begin
            if (r % 3 == 0) write_buckets(6'($urandom_range(32, 1)));
            quiet = (r == 5);
            case ($urandom_range(4))
                0: k = PK_RAMP_X;
                1: k = PK_RAMP_Y;
                default: k = PK_NOISE;
            endcase
            send_patch(k, (k == PK_NOISE && $urandom_range(1)) ? 0 : $urandom_range(1000, 10),
                       1'b1);
        end
        quiet = 1'b0;
        drain();
        repeat (400) @(posedge i_clk);
        if (!failed && desc_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

[sim.f]
design/sbd_pkg.sv
design/sbd_ram.sv
design/sbd_front.sv
design/sbd_back.sv
design/steered_brief_descriptor.sv
bench/tb.sv
